[design/frame_slot_ring_manager_defines.svh]
// ---------------------------------------------------------------------------
// Frame slot ring manager: assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef FRAME_SLOT_RING_MANAGER_DEFINES_SVH
`define FRAME_SLOT_RING_MANAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define FSR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsr assertion failed");

// next-cycle implication
`define FSR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsr assertion failed");

`else

`define FSR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FSR_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

[design/fsr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsr_pkg
// Types and codes shared by the frame slot ring manager modules.
// ---------------------------------------------------------------------------
package fsr_pkg;

  localparam int SLOT_W = 4;
  localparam int CFG_W  = 5;

  // request codes
  localparam logic [1:0] REQ_WR_ACQ = 2'd0;
  localparam logic [1:0] REQ_RD_ACQ = 2'd1;
  localparam logic [1:0] REQ_RETURN = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  // slot ownership states
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_WRITING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_READING = 2'd3;

  // response status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_REFUSED = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        slot_state;
  } rsp_t;

  // pointer advance requests from the controller
  typedef struct packed {
    logic adv_wr;
    logic adv_rd;
  } ptr_adv_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

endpackage

[design/fsr_slot_mem.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsr_slot_mem
// Slot state memory: one write port, one registered read port. Per-entry
// valid bits give the all-empty state straight after reset.
// ---------------------------------------------------------------------------
module fsr_slot_mem
  import fsr_pkg::*;
#(
  parameter int MAX_SLOTS = 16,
  parameter int PTR_W     = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             re,
  input  logic [PTR_W-1:0] raddr,
  output logic [1:0]       rdata,
  input  logic             we,
  input  logic [PTR_W-1:0] waddr,
  input  logic [1:0]       wdata
);

  logic [1:0]           mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] vld;
  logic [1:0]           rd_q;
  logic                 rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q   <= mem[raddr];
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = rd_vld ? rd_q : ST_EMPTY;

endmodule

[design/fsr_ring_ptrs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsr_ring_ptrs
// Write and read ring pointers. Presents the pointers folded back to slot 0
// when the ring has shrunk below them, and advances them with wrap.
// ---------------------------------------------------------------------------
module fsr_ring_ptrs
  import fsr_pkg::*;
#(
  parameter int PTR_W = 4,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] n_eff,
  input  ptr_adv_t         adv,
  output logic [PTR_W-1:0] wp_eff,
  output logic [PTR_W-1:0] rp_eff
);

  logic [PTR_W-1:0] write_ptr, read_ptr;
  logic [PTR_W-1:0] write_ptr_next, read_ptr_next;
  logic [CNT_W-1:0] wp_inc, rp_inc;

  assign wp_eff = (CNT_W'(write_ptr) >= n_eff) ? '0 : write_ptr;
  assign rp_eff = (CNT_W'(read_ptr) >= n_eff) ? '0 : read_ptr;

  assign wp_inc = CNT_W'(wp_eff) + CNT_W'(1);
  assign rp_inc = CNT_W'(rp_eff) + CNT_W'(1);

  always_comb begin
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    if (adv.adv_wr) begin
      write_ptr_next = (wp_inc >= n_eff) ? '0 : PTR_W'(wp_inc);
    end
    if (adv.adv_rd) begin
      read_ptr_next = (rp_inc >= n_eff) ? '0 : PTR_W'(rp_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
    end else begin
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
    end
  end

endmodule

[design/frame_slot_ring_manager.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_slot_ring_manager
// Slot ownership tracker for a ring of frame buffers shared by a producer
// and a consumer.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready/in_data (req_type, slot_index);
//   responses leave on out_valid/out_ready/out_data (status, slot,
//   slot_state), exactly one per request, in order.
//   The slot_count register is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high. Write it only while no request is in flight.
//   Each request has an accept cycle, which issues the registered slot
//   state memory read, then an execute state, which modifies, writes back
//   and loads the response register once the output register is free.
//   One request is in flight at a time: the next is accepted only after the
//   execute state ends; out_valid is registered and rises as that state ends.
//   A response may wait in the output register while the next request is
//   accepted; that request then holds in the execute state until the output
//   register is taken.
//   Reset (synchronous, rst high) empties every slot, zeroes both pointers,
//   sets slot_count to 16 and drops out_valid.
// ---------------------------------------------------------------------------
`include "frame_slot_ring_manager_defines.svh"

module frame_slot_ring_manager
  import fsr_pkg::*;
#(
  parameter int MAX_SLOTS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int PTR_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  fsm_t             state, state_next;
  logic [CFG_W-1:0] slot_count;
  logic [CNT_W-1:0] n_eff;

  logic             in_acc, out_free, exec_done, rd_en;
  logic [PTR_W-1:0] wp_eff, rp_eff, rd_addr;

  // request held across the memory read
  logic [1:0]        req;
  logic [SLOT_W-1:0] idx;
  logic [PTR_W-1:0]  addr;
  logic              oor;

  logic [1:0]       cur_st;
  logic             we;
  logic [1:0]       wdata;
  ptr_adv_t         adv;
  rsp_t             rsp;
  logic             out_valid_next;

  // ---- configuration ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= CFG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      slot_count <= cfg_data;
    end
  end

  // zero acts as one, anything above the ring size acts as the ring size
  always_comb begin
    if (slot_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(slot_count) > MAX_SLOTS) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end else begin
      n_eff = CNT_W'(slot_count);
    end
  end

  // ---- control ----
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign exec_done = (state == FSM_EXEC) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: if (in_valid) state_next = FSM_EXEC;
      FSM_EXEC: if (out_free) state_next = FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    unique case (state)
      FSM_IDLE: in_ready = 1'b1;
      FSM_EXEC: in_ready = 1'b0;
      default:  in_ready = 1'b0;
    endcase
  end

  assign rd_en = in_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (in_data.req_type)
      REQ_WR_ACQ: rd_addr = wp_eff;
      REQ_RD_ACQ: rd_addr = rp_eff;
      default:    rd_addr = PTR_W'(in_data.slot_index);
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req  <= in_data.req_type;
      idx  <= in_data.slot_index;
      addr <= rd_addr;
      oor  <= (CNT_W + SLOT_W)'(in_data.slot_index) >= (CNT_W + SLOT_W)'(n_eff);
    end
  end

  // ---- state memory and pointers ----
  fsr_slot_mem #(
    .MAX_SLOTS(MAX_SLOTS),
    .PTR_W    (PTR_W)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(cur_st),
    .we   (we),
    .waddr(addr),
    .wdata(wdata)
  );

  fsr_ring_ptrs #(
    .PTR_W(PTR_W),
    .CNT_W(CNT_W)
  ) u_ptrs (
    .clk   (clk),
    .rst   (rst),
    .n_eff (n_eff),
    .adv   (adv),
    .wp_eff(wp_eff),
    .rp_eff(rp_eff)
  );

  // ---- modify ----
  always_comb begin
    we              = 1'b0;
    wdata           = cur_st;
    adv             = '0;
    rsp.status      = STAT_REFUSED;
    rsp.slot        = idx;
    rsp.slot_state  = cur_st;
    case (req) inside
      REQ_WR_ACQ, REQ_RD_ACQ: begin
        rsp.slot = SLOT_W'(addr);
        if (req == REQ_WR_ACQ && cur_st == ST_EMPTY) begin
          we             = exec_done;
          wdata          = ST_WRITING;
          adv.adv_wr     = exec_done;
          rsp.status     = STAT_OK;
          rsp.slot_state = ST_WRITING;
        end else if (req == REQ_RD_ACQ && cur_st == ST_FULL) begin
          we             = exec_done;
          wdata          = ST_READING;
          adv.adv_rd     = exec_done;
          rsp.status     = STAT_OK;
          rsp.slot_state = ST_READING;
        end
      end
      REQ_RETURN: begin
        if (oor) begin
          rsp.status     = STAT_RANGE;
          rsp.slot_state = ST_EMPTY;
        end else if (cur_st == ST_WRITING || cur_st == ST_READING) begin
          we             = exec_done;
          wdata          = (cur_st == ST_WRITING) ? ST_FULL : ST_EMPTY;
          rsp.status     = STAT_OK;
          rsp.slot_state = wdata;
        end
      end
      default: begin
        if (oor) begin
          rsp.status     = STAT_RANGE;
          rsp.slot_state = ST_EMPTY;
        end else begin
          rsp.status = STAT_OK;
        end
      end
    endcase
  end

  // ---- response register ----
  always_comb begin
    out_valid_next = out_valid;
    if (exec_done) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      out_data <= rsp;
    end
  end

  // ---- assertions ----
  `FSR_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  `FSR_ASSERT_NXT(a_write_gives_rsp, clk, rst, we, out_valid)
  `FSR_ASSERT_IMP(a_range_reads_empty, clk, rst,
                  out_valid && out_data.status == STAT_RANGE,
                  out_data.slot_state == ST_EMPTY)

endmodule
